// ===== rtl/core/pending_query_tracker_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef PENDING_QUERY_TRACKER_UNIT_MACROS_SVH
`define PENDING_QUERY_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PQT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pending query tracker check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PQT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pending query tracker check failed");

`endif

// ===== rtl/core/pqt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqt_pkg
// Types, codes and constants shared by the pending query tracker modules.
// ----------------------------------------------------------------------------
package pqt_pkg;

	localparam int SLOTS_DEFAULT = 32;
	localparam int MAX_RESULTS = 32;
	localparam int CMD_QUEUE_DEPTH = 2;
	localparam logic [31:0] TRANS_ID_RESET = 32'h494e0001;
	localparam logic [15:0] TIMEOUT_RESET = 16'd5;
	localparam logic [15:0] TIMEOUT_FALLBACK = 16'd5;

	// function codes of an input item
	localparam logic [2:0] FN_QUERY = 3'd0;
	localparam logic [2:0] FN_TREPLY = 3'd1;
	localparam logic [2:0] FN_SREPLY = 3'd2;
	localparam logic [2:0] FN_TICK = 3'd3;
	localparam logic [2:0] FN_CANCEL = 3'd4;

	// modes
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_SIP_AS = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_ACCEPTED = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_NOMATCH = 2'd2;
	localparam logic [1:0] KIND_WAIT = 2'd3;

	// verdicts
	localparam logic [1:0] VERDICT_CONT = 2'd0;
	localparam logic [1:0] VERDICT_CONNECT = 2'd1;
	localparam logic [1:0] VERDICT_FAIL = 2'd2;

	// reply verdict codes
	localparam logic [2:0] RV_CONTINUE = 3'd1;
	localparam logic [2:0] RV_CONNECT = 3'd2;

	// register indexes
	localparam logic [1:0] REG_DEFAULT_MODE = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_SCP_CFG = 2'd2;
	localparam logic [1:0] REG_SIP_CFG = 2'd3;

	// SIP status class bounds
	localparam logic [9:0] SIP_RINGING_LO = 10'd180;
	localparam logic [9:0] SIP_OK_LO = 10'd200;
	localparam logic [9:0] SIP_REDIR_LO = 10'd300;
	localparam logic [9:0] SIP_FAIL_LO = 10'd400;

	typedef enum logic [2:0] {
		OP_IGNORE = 3'd0,
		OP_QDONE = 3'd1,
		OP_QUERY = 3'd2,
		OP_TREPLY = 3'd3,
		OP_SREPLY = 3'd4,
		OP_TICK = 3'd5,
		OP_CANCEL = 3'd6
	} op_t;

	typedef struct packed {
		op_t op;
		logic [31:0] call_id;
		logic [1:0] mode;
		logic ok;
		logic [31:0] key1;
		logic [31:0] key2;
		logic has_o;
		logic [1:0] verdict;
		logic wait_final;
		logic [31:0] now;
		logic [15:0] tmo;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] call_id;
		logic [31:0] trans_id;
		logic [1:0] verdict;
	} rsp_t;

	typedef struct packed {
		logic [31:0] call_id;
		logic [31:0] trans_id;
		logic [1:0] mode;
		logic [31:0] start;
	} slot_t;

	typedef struct packed {
		logic [1:0] default_mode;
		logic [15:0] timeout;
		logic scp_cfg;
		logic sip_cfg;
	} cfg_t;

endpackage

// ===== rtl/core/pqt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqt_front
// Resolves mode, reply verdict and timeout of an item into a command.
// ----------------------------------------------------------------------------
module pqt_front (
	input pqt_pkg::cfg_t cfg,
	input logic [2:0] func,
	input logic [31:0] call_id,
	input logic signed [2:0] mode_sel,
	input logic [31:0] dest_trans_id,
	input logic has_dest_trans,
	input logic [31:0] orig_trans_id,
	input logic has_orig_trans,
	input logic [2:0] reply_verdict,
	input logic dest_found,
	input logic [9:0] sip_status,
	input logic [31:0] now_seconds,
	output pqt_pkg::cmd_t cmd
);

	logic [1:0] mode;
	logic [1:0] tverdict;
	logic [1:0] sverdict;
	logic swait;

	assign mode = mode_sel[2] ? cfg.default_mode : mode_sel[1:0];

	always_comb begin
		if (reply_verdict == pqt_pkg::RV_CONTINUE) begin
			tverdict = pqt_pkg::VERDICT_CONT;
		end else if (reply_verdict == pqt_pkg::RV_CONNECT) begin
			tverdict = dest_found ? pqt_pkg::VERDICT_CONNECT : pqt_pkg::VERDICT_CONT;
		end else begin
			tverdict = pqt_pkg::VERDICT_FAIL;
		end
	end

	always_comb begin
		swait = 1'b0;
		priority if (sip_status >= pqt_pkg::SIP_OK_LO && sip_status < pqt_pkg::SIP_REDIR_LO) begin
			sverdict = pqt_pkg::VERDICT_CONT;
		end else if (sip_status >= pqt_pkg::SIP_REDIR_LO
			&& sip_status < pqt_pkg::SIP_FAIL_LO) begin
			sverdict = dest_found ? pqt_pkg::VERDICT_CONNECT : pqt_pkg::VERDICT_CONT;
		end else if (sip_status >= pqt_pkg::SIP_RINGING_LO
			&& sip_status < pqt_pkg::SIP_OK_LO) begin
			sverdict = pqt_pkg::VERDICT_CONT;
			swait = 1'b1;
		end else begin
			sverdict = pqt_pkg::VERDICT_FAIL;
		end
	end

	always_comb begin
		cmd.call_id = call_id;
		cmd.mode = mode;
		cmd.ok = (mode == pqt_pkg::MODE_SIP_AS) ? cfg.sip_cfg : cfg.scp_cfg;
		cmd.key1 = has_dest_trans ? dest_trans_id : (has_orig_trans ? orig_trans_id : 32'd0);
		cmd.key2 = orig_trans_id;
		cmd.has_o = has_orig_trans;
		cmd.verdict = (func == pqt_pkg::FN_SREPLY) ? sverdict : tverdict;
		cmd.wait_final = swait;
		cmd.now = now_seconds;
		cmd.tmo = (cfg.timeout == 16'd0) ? pqt_pkg::TIMEOUT_FALLBACK : cfg.timeout;
		unique case (func)
			pqt_pkg::FN_QUERY: begin
				cmd.op = (mode == pqt_pkg::MODE_NONE) ? pqt_pkg::OP_QDONE : pqt_pkg::OP_QUERY;
			end
			pqt_pkg::FN_TREPLY: cmd.op = pqt_pkg::OP_TREPLY;
			pqt_pkg::FN_SREPLY: cmd.op = pqt_pkg::OP_SREPLY;
			pqt_pkg::FN_TICK: cmd.op = pqt_pkg::OP_TICK;
			pqt_pkg::FN_CANCEL: cmd.op = pqt_pkg::OP_CANCEL;
			default: cmd.op = pqt_pkg::OP_IGNORE;
		endcase
	end

endmodule

// ===== rtl/core/pqt_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqt_cmd_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module pqt_cmd_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input pqt_pkg::cmd_t push_cmd,
	output logic full,
	input logic pop,
	output logic empty,
	output pqt_pkg::cmd_t pop_cmd
);

	localparam int DEPTH = pqt_pkg::CMD_QUEUE_DEPTH;
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pqt_pkg::cmd_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

// ===== rtl/core/pqt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqt_back
// Slot table and scanner, one slot per cycle unless stalled; result register.
// ----------------------------------------------------------------------------
module pqt_back #(
	parameter int SLOTS = pqt_pkg::SLOTS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_avail,
	input pqt_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic rsp_valid,
	input logic rsp_ready,
	output pqt_pkg::rsp_t rsp,
	output logic rsp_last
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int NW = $clog2(pqt_pkg::MAX_RESULTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t state_q;
	pqt_pkg::cmd_t cmd_q;
	pqt_pkg::slot_t slot_mem [SLOTS];
	pqt_pkg::slot_t rdata_s1;
	logic cmp_v_s1;
	logic [IW-1:0] cmp_idx_s1;
	logic [CW-1:0] rd_idx_q;
	logic pass_q;
	logic [NW-1:0] n_q;
	logic [SLOTS-1:0] slot_valid_q;
	logic [31:0] next_tid_q;
	logic hold_v_q;
	pqt_pkg::rsp_t hold_q;
	logic rsp_valid_q;
	pqt_pkg::rsp_t rsp_q;
	logic rsp_last_q;

	logic cur_valid;
	logic [31:0] key;
	logic [31:0] age;
	logic hit;
	logic out_free;
	logic stall;
	logic scan_end;
	logic mem_we;
	logic rsp_load;
	pqt_pkg::slot_t mem_wdata;
	logic [31:0] tid_inc;

	assign cur_valid = slot_valid_q[cmp_idx_s1];
	assign key = pass_q ? cmd_q.key2 : cmd_q.key1;
	assign age = cmd_q.now - rdata_s1.start;
	assign out_free = !rsp_valid_q || rsp_ready;
	assign tid_inc = next_tid_q + 32'd1;

	always_comb begin
		unique case (cmd_q.op)
			pqt_pkg::OP_QUERY: hit = !cur_valid;
			pqt_pkg::OP_TREPLY: hit = cur_valid && (rdata_s1.trans_id == key);
			pqt_pkg::OP_SREPLY: begin
				hit = cur_valid && (rdata_s1.mode == pqt_pkg::MODE_SIP_AS)
					&& (rdata_s1.call_id == cmd_q.call_id);
			end
			pqt_pkg::OP_TICK: hit = cur_valid && (age >= {16'd0, cmd_q.tmo});
			pqt_pkg::OP_CANCEL: hit = cur_valid && (rdata_s1.call_id == cmd_q.call_id);
			default: hit = 1'b0;
		endcase
	end

	assign stall = (state_q == ST_SCAN) && cmp_v_s1 && hit
		&& (cmd_q.op == pqt_pkg::OP_TICK) && hold_v_q && !out_free;
	assign scan_end = !cmp_v_s1 && (rd_idx_q == CW'(SLOTS));
	assign cmd_pop = (state_q == ST_IDLE) && cmd_avail;
	assign mem_we = (state_q == ST_SCAN) && cmp_v_s1 && hit
		&& (cmd_q.op == pqt_pkg::OP_QUERY) && cmd_q.ok;
	// load the result register from the held item
	assign rsp_load = ((state_q == ST_SCAN) && cmp_v_s1 && hit
		&& (cmd_q.op == pqt_pkg::OP_TICK) && hold_v_q && out_free)
		|| ((state_q == ST_FLUSH) && hold_v_q && out_free);

	always_comb begin
		mem_wdata.call_id = cmd_q.call_id;
		mem_wdata.trans_id = next_tid_q;
		mem_wdata.mode = cmd_q.mode;
		mem_wdata.start = cmd_q.now;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[cmp_idx_s1] <= mem_wdata;
		end
		if (state_q == ST_SCAN && !stall && rd_idx_q != CW'(SLOTS)) begin
			rdata_s1 <= slot_mem[rd_idx_q[IW-1:0]];
		end
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmp_v_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			rd_idx_q <= '0;
			pass_q <= 1'b0;
			n_q <= '0;
			slot_valid_q <= '0;
			next_tid_q <= pqt_pkg::TRANS_ID_RESET;
			hold_v_q <= 1'b0;
			hold_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
			rsp_last_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_avail) begin
						rd_idx_q <= '0;
						pass_q <= 1'b0;
						n_q <= '0;
						cmp_v_s1 <= 1'b0;
						hold_v_q <= (cmd.op == pqt_pkg::OP_QDONE);
						if (cmd.op == pqt_pkg::OP_QDONE) begin
							hold_q <= '{pqt_pkg::KIND_DONE, cmd.call_id, 32'd0,
								pqt_pkg::VERDICT_CONT};
							state_q <= ST_FLUSH;
						end else if (cmd.op != pqt_pkg::OP_IGNORE) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (!stall) begin
						cmp_v_s1 <= (rd_idx_q != CW'(SLOTS));
						cmp_idx_s1 <= rd_idx_q[IW-1:0];
						if (rd_idx_q != CW'(SLOTS)) begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
					if (cmp_v_s1 && hit && !stall) begin
						unique case (cmd_q.op)
							pqt_pkg::OP_QUERY: begin
								next_tid_q <= (tid_inc == 32'd0) ? 32'd1 : tid_inc;
								hold_v_q <= 1'b1;
								if (cmd_q.ok) begin
									slot_valid_q[cmp_idx_s1] <= 1'b1;
									hold_q <= '{pqt_pkg::KIND_ACCEPTED, cmd_q.call_id,
										next_tid_q, pqt_pkg::VERDICT_CONT};
								end else begin
									hold_q <= '{pqt_pkg::KIND_DONE, cmd_q.call_id,
										next_tid_q, pqt_pkg::VERDICT_FAIL};
								end
								state_q <= ST_FLUSH;
							end
							pqt_pkg::OP_TREPLY: begin
								slot_valid_q[cmp_idx_s1] <= 1'b0;
								hold_v_q <= 1'b1;
								hold_q <= '{pqt_pkg::KIND_DONE, rdata_s1.call_id,
									rdata_s1.trans_id, cmd_q.verdict};
								state_q <= ST_FLUSH;
							end
							pqt_pkg::OP_SREPLY: begin
								hold_v_q <= 1'b1;
								if (cmd_q.wait_final) begin
									hold_q <= '{pqt_pkg::KIND_WAIT, rdata_s1.call_id,
										rdata_s1.trans_id, pqt_pkg::VERDICT_CONT};
								end else begin
									slot_valid_q[cmp_idx_s1] <= 1'b0;
									hold_q <= '{pqt_pkg::KIND_DONE, rdata_s1.call_id,
										rdata_s1.trans_id, cmd_q.verdict};
								end
								state_q <= ST_FLUSH;
							end
							pqt_pkg::OP_TICK: begin
								// hand the previous expiry on, keep this one back
								slot_valid_q[cmp_idx_s1] <= 1'b0;
								if (hold_v_q) begin
									rsp_q <= hold_q;
									rsp_last_q <= 1'b0;
								end
								hold_v_q <= 1'b1;
								hold_q <= '{pqt_pkg::KIND_DONE, rdata_s1.call_id,
									rdata_s1.trans_id, pqt_pkg::VERDICT_FAIL};
								n_q <= n_q + 1'b1;
								if (n_q == NW'(pqt_pkg::MAX_RESULTS - 1)) begin
									state_q <= ST_FLUSH;
								end
							end
							pqt_pkg::OP_CANCEL: begin
								slot_valid_q[cmp_idx_s1] <= 1'b0;
								state_q <= ST_FLUSH;
							end
							default: state_q <= ST_FLUSH;
						endcase
					end else if (scan_end) begin
						if (cmd_q.op == pqt_pkg::OP_TREPLY && !pass_q && cmd_q.has_o) begin
							pass_q <= 1'b1;
							rd_idx_q <= '0;
						end else begin
							if (cmd_q.op == pqt_pkg::OP_QUERY) begin
								hold_v_q <= 1'b1;
								hold_q <= '{pqt_pkg::KIND_DONE, cmd_q.call_id, 32'd0,
									pqt_pkg::VERDICT_FAIL};
							end else if (cmd_q.op == pqt_pkg::OP_TREPLY
								|| cmd_q.op == pqt_pkg::OP_SREPLY) begin
								hold_v_q <= 1'b1;
								hold_q <= '{pqt_pkg::KIND_NOMATCH, cmd_q.call_id, 32'd0,
									pqt_pkg::VERDICT_CONT};
							end
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!hold_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						rsp_q <= hold_q;
						rsp_last_q <= 1'b1;
						hold_v_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign rsp_last = rsp_last_q;

endmodule

// ===== rtl/core/pending_query_tracker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_query_tracker_unit
// Tracks outstanding service queries in a slot table and resolves replies,
// timeouts and cancels against it.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  req       req_valid/req_ready    func .. now_seconds
//  rsp       rsp_valid/rsp_ready    out_kind, out_call_id, out_trans_id,
//                                   verdict, last
//  config    APB psel/penable       paddr[3:2] selects the register
//
// A query in mode none goes straight to flush; other codes but an ignored
// one scan the table, and a transaction reply that misses on its first key
// scans again. One slot is examined per cycle through the registered read of
// the slot memory, unless a tick stalls on a busy result register. Two
// commands queue between front and back, so req stays ready until two items
// wait behind the running scan. A stalled rsp holds the scan only when a tick
// finds a further expiry, and holds the final result until it drains. Reset
// clears every slot's valid bit at once; no clearing pass is needed.
module pending_query_tracker_unit #(
	parameter int SLOTS = pqt_pkg::SLOTS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	// configuration
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	// request items
	input logic req_valid,
	output logic req_ready,
	input logic [2:0] func,
	input logic [31:0] call_id,
	input logic signed [2:0] mode_sel,
	input logic [31:0] dest_trans_id,
	input logic has_dest_trans,
	input logic [31:0] orig_trans_id,
	input logic has_orig_trans,
	input logic [2:0] reply_verdict,
	input logic dest_found,
	input logic [9:0] sip_status,
	input logic [31:0] now_seconds,
	// result items
	output logic rsp_valid,
	input logic rsp_ready,
	output logic [1:0] out_kind,
	output logic [31:0] out_call_id,
	output logic [31:0] out_trans_id,
	output logic [1:0] verdict,
	output logic last
);

	pqt_pkg::cfg_t cfg_q;
	pqt_pkg::cmd_t front_cmd;
	pqt_pkg::cmd_t queue_cmd;
	pqt_pkg::rsp_t rsp;
	logic queue_full;
	logic queue_empty;
	logic cmd_pop;
	logic cfg_wr;

	// Register file: written in the access phase, read back at any time.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.default_mode <= pqt_pkg::MODE_NONE;
			cfg_q.timeout <= pqt_pkg::TIMEOUT_RESET;
			cfg_q.scp_cfg <= 1'b0;
			cfg_q.sip_cfg <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				pqt_pkg::REG_DEFAULT_MODE: cfg_q.default_mode <= pwdata[1:0];
				pqt_pkg::REG_TIMEOUT: cfg_q.timeout <= pwdata[15:0];
				pqt_pkg::REG_SCP_CFG: cfg_q.scp_cfg <= pwdata[0];
				pqt_pkg::REG_SIP_CFG: cfg_q.sip_cfg <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			pqt_pkg::REG_DEFAULT_MODE: prdata = {30'd0, cfg_q.default_mode};
			pqt_pkg::REG_TIMEOUT: prdata = {16'd0, cfg_q.timeout};
			pqt_pkg::REG_SCP_CFG: prdata = {31'd0, cfg_q.scp_cfg};
			pqt_pkg::REG_SIP_CFG: prdata = {31'd0, cfg_q.sip_cfg};
		endcase
	end

	// Front: classify the item while it is pushed into the command queue.
	pqt_front u_front (
		.cfg(cfg_q),
		.func(func),
		.call_id(call_id),
		.mode_sel(mode_sel),
		.dest_trans_id(dest_trans_id),
		.has_dest_trans(has_dest_trans),
		.orig_trans_id(orig_trans_id),
		.has_orig_trans(has_orig_trans),
		.reply_verdict(reply_verdict),
		.dest_found(dest_found),
		.sip_status(sip_status),
		.now_seconds(now_seconds),
		.cmd(front_cmd)
	);

	assign req_ready = !queue_full;

	pqt_cmd_fifo u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(req_valid),
		.push_cmd(front_cmd),
		.full(queue_full),
		.pop(cmd_pop),
		.empty(queue_empty),
		.pop_cmd(queue_cmd)
	);

	// Back: scan the slot table and drive the result register.
	pqt_back #(
		.SLOTS(SLOTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_avail(!queue_empty),
		.cmd(queue_cmd),
		.cmd_pop(cmd_pop),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.rsp_last(last)
	);

	assign out_kind = rsp.kind;
	assign out_call_id = rsp.call_id;
	assign out_trans_id = rsp.trans_id;
	assign verdict = rsp.verdict;

endmodule

// ===== rtl/core/pqt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqt_checker
// Port-level checks of the pending query tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "pending_query_tracker_unit_macros.svh"

module pqt_checker (
	input logic clk,
	input logic arst_n,
	input logic pready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [1:0] out_kind,
	input logic [31:0] out_trans_id,
	input logic [1:0] verdict
);

	`PQT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(out_trans_id))
	`PQT_ASSERT_NOW(a_verdict_kind, rsp_valid && out_kind != pqt_pkg::KIND_DONE, verdict == pqt_pkg::VERDICT_CONT)
	`PQT_ASSERT_NOW(a_accept_tid, rsp_valid && out_kind == pqt_pkg::KIND_ACCEPTED, out_trans_id != 32'd0)
	`PQT_ASSERT_NOW(a_nomatch_tid, rsp_valid && out_kind == pqt_pkg::KIND_NOMATCH, out_trans_id == 32'd0)

	logic unused_pready;
	assign unused_pready = pready;

endmodule

bind pending_query_tracker_unit pqt_checker u_pqt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.pready(pready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.out_kind(out_kind),
	.out_trans_id(out_trans_id),
	.verdict(verdict)
);
